[hdl/tlca_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tree common ancestor package
// Shared widths, types, micro-op codes and row access helpers.
// ----------------------------------------------------------------------------
package tlca_pkg;

    localparam int NODES     = 1024;
    localparam int LEVELS    = 10;
    localparam int ID_W      = 10;
    localparam int DEPTH_W   = 10;
    localparam int ADDR_W    = $clog2(NODES);
    localparam int LVL_W     = $clog2(LEVELS);
    localparam int WORD_W    = LEVELS * ID_W + DEPTH_W;
    localparam int DEPTH_MAX = 2 ** DEPTH_W - 1;

    typedef logic [ID_W-1:0]    t_id;
    typedef logic [DEPTH_W-1:0] t_depth;
    typedef logic [LVL_W-1:0]   t_lvl;
    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [WORD_W-1:0]  t_word;
    typedef logic [LEVELS-1:0][ID_W-1:0] t_row;

    // Datapath operation selected by the current control word
    typedef enum logic [3:0] {
        OP_NOP,
        OP_CLEAR,
        OP_ACCEPT,
        OP_ATT_INIT,
        OP_ATT_STEP,
        OP_ATT_WRITE,
        OP_Q_SWAP,
        OP_Q_LIFT,
        OP_Q_CHECK,
        OP_Q_JUMP,
        OP_EMIT_UP,
        OP_EMIT_A
    } t_op;

    // Status fed back from the datapath to the sequencer
    typedef struct packed {
        logic clr_busy;
        logic no_txn;
        logic query;
        logic k_up_more;
        logic k_dn_more;
        logic same;
        logic out_busy;
    } t_flags;

    // Row layout: depth on top, level k ancestor at bits [k*ID_W +: ID_W]
    function automatic t_id anc_of(input t_word w, input t_lvl k);
        anc_of = w[k*ID_W +: ID_W];
    endfunction

    function automatic t_depth depth_of(input t_word w);
        depth_of = w[WORD_W-1 -: DEPTH_W];
    endfunction

    // Ids at or beyond the node count mean no node
    function automatic t_id clamp_id(input t_id v);
        clamp_id = (32'(v) < NODES) ? v : '0;
    endfunction

endpackage

[hdl/tlca_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module tlca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata_a <= mem[i_raddr_a];
    end

    always_ff @(posedge i_clk) begin
        o_rdata_b <= mem[i_raddr_b];
    end

endmodule

[hdl/tlca_useq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tree common ancestor sequencer
// Step counter and control store; picks the datapath op and the next step.
// ----------------------------------------------------------------------------
module tlca_useq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tlca_pkg::t_flags i_flags,
    output tlca_pkg::t_op   o_op
);
    import tlca_pkg::*;

    typedef logic [3:0] t_step;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_CLR_BUSY,
        C_NO_TXN,
        C_QUERY,
        C_K_UP,
        C_K_DN,
        C_SAME,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond hold;
        t_cond jump;
        t_step target;
    } t_uword;

    localparam t_step ST_CLR      = 4'd0;
    localparam t_step ST_IDLE     = 4'd1;
    localparam t_step ST_DISPATCH = 4'd2;
    localparam t_step ST_ATT_STEP = 4'd3;
    localparam t_step ST_ATT_WR   = 4'd4;
    localparam t_step ST_Q_SWAP   = 4'd5;
    localparam t_step ST_Q_LIFT   = 4'd6;
    localparam t_step ST_Q_CHECK  = 4'd7;
    localparam t_step ST_Q_JUMP   = 4'd8;
    localparam t_step ST_EMIT_UP  = 4'd9;
    localparam t_step ST_EMIT_A   = 4'd10;

    t_step  r_step;
    t_step  n_step;
    t_uword uw;

    // Control store
    always_comb begin
        case (r_step)
            ST_CLR:      uw = '{OP_CLEAR,     C_CLR_BUSY, C_NEVER,  ST_CLR};
            ST_IDLE:     uw = '{OP_ACCEPT,    C_NO_TXN,   C_NEVER,  ST_IDLE};
            ST_DISPATCH: uw = '{OP_ATT_INIT,  C_NEVER,    C_QUERY,  ST_Q_SWAP};
            ST_ATT_STEP: uw = '{OP_ATT_STEP,  C_NEVER,    C_K_UP,   ST_ATT_STEP};
            ST_ATT_WR:   uw = '{OP_ATT_WRITE, C_NEVER,    C_ALWAYS, ST_IDLE};
            ST_Q_SWAP:   uw = '{OP_Q_SWAP,    C_NEVER,    C_NEVER,  ST_Q_LIFT};
            ST_Q_LIFT:   uw = '{OP_Q_LIFT,    C_NEVER,    C_K_DN,   ST_Q_LIFT};
            ST_Q_CHECK:  uw = '{OP_Q_CHECK,   C_NEVER,    C_SAME,   ST_EMIT_A};
            ST_Q_JUMP:   uw = '{OP_Q_JUMP,    C_NEVER,    C_K_DN,   ST_Q_JUMP};
            ST_EMIT_UP:  uw = '{OP_EMIT_UP,   C_OUT_BUSY, C_ALWAYS, ST_IDLE};
            ST_EMIT_A:   uw = '{OP_EMIT_A,    C_OUT_BUSY, C_ALWAYS, ST_IDLE};
            default:     uw = '{OP_NOP,       C_NEVER,    C_ALWAYS, ST_IDLE};
        endcase
    end

    function automatic logic test(input t_cond c, input t_flags f);
        case (c)
            C_NEVER:    test = 1'b0;
            C_ALWAYS:   test = 1'b1;
            C_CLR_BUSY: test = f.clr_busy;
            C_NO_TXN:   test = f.no_txn;
            C_QUERY:    test = f.query;
            C_K_UP:     test = f.k_up_more;
            C_K_DN:     test = f.k_dn_more;
            C_SAME:     test = f.same;
            C_OUT_BUSY: test = f.out_busy;
            default:    test = 1'b0;
        endcase
    endfunction

    always_comb begin
        if (test(uw.hold, i_flags)) begin
            n_step = r_step;
        end else if (test(uw.jump, i_flags)) begin
            n_step = uw.target;
        end else begin
            n_step = t_step'(r_step + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_CLR;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_op = uw.op;

endmodule

[hdl/tlca_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tree common ancestor datapath
// Node registers, level counter, row builder, output register and RAM ports.
// ----------------------------------------------------------------------------
module tlca_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tlca_pkg::t_op    i_op,
    output tlca_pkg::t_flags o_flags,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_req_type,
    input  tlca_pkg::t_id    i_node_a,
    input  tlca_pkg::t_id    i_node_b,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output tlca_pkg::t_id    o_ancestor,
    output logic             o_we,
    output tlca_pkg::t_addr  o_waddr,
    output tlca_pkg::t_word  o_wdata,
    output tlca_pkg::t_addr  o_raddr_a,
    output tlca_pkg::t_addr  o_raddr_b,
    input  tlca_pkg::t_word  i_rdata_a,
    input  tlca_pkg::t_word  i_rdata_b
);
    import tlca_pkg::*;

    t_id    r_a, n_a;
    t_id    r_b, n_b;
    t_lvl   r_k, n_k;
    t_row   r_row;
    t_depth r_dn;
    logic   r_query;
    t_addr  r_clr;
    logic   r_out_valid;
    t_id    r_out_anc;

    t_depth da, db, gap;
    t_id    up_a, up_b, chain;
    logic   out_busy, emit;

    assign da    = depth_of(i_rdata_a);
    assign db    = depth_of(i_rdata_b);
    assign gap   = t_depth'(db - da);
    assign up_a  = anc_of(i_rdata_a, r_k);
    assign up_b  = anc_of(i_rdata_b, r_k);
    // Next attach ancestor; a node that reaches itself stays put
    assign chain = (r_b == r_a) ? r_a : anc_of(i_rdata_b, t_lvl'(r_k - 1'b1));

    assign out_busy = r_out_valid && i_out_stall;
    assign emit     = (i_op inside {OP_EMIT_UP, OP_EMIT_A}) && !out_busy;

    always_comb begin
        n_a = r_a;
        n_b = r_b;
        n_k = r_k;
        case (i_op)
            OP_ACCEPT: begin
                if (i_in_valid) begin
                    n_a = clamp_id(i_node_a);
                    n_b = clamp_id(i_node_b);
                end
            end
            OP_ATT_INIT: begin
                n_k = t_lvl'(1);
            end
            OP_ATT_STEP: begin
                n_b = chain;
                n_k = t_lvl'(r_k + 1'b1);
            end
            OP_Q_SWAP: begin
                if (da > db) begin
                    n_a = r_b;
                    n_b = r_a;
                end
                n_k = t_lvl'(LEVELS - 1);
            end
            OP_Q_LIFT: begin
                if (db > da && (gap >> r_k) != '0) begin
                    n_b = up_b;
                end
                n_k = t_lvl'(r_k - 1'b1);
            end
            OP_Q_CHECK: begin
                n_k = t_lvl'(LEVELS - 1);
            end
            OP_Q_JUMP: begin
                if (up_a != up_b) begin
                    n_a = up_a;
                    n_b = up_b;
                end
                n_k = t_lvl'(r_k - 1'b1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        r_b <= n_b;
        r_k <= n_k;
        if (i_op == OP_ACCEPT && i_in_valid) begin
            r_query <= i_req_type;
        end
        if (i_op == OP_ATT_INIT) begin
            r_row[0] <= r_b;
            r_dn     <= (32'(db) == DEPTH_MAX) ? db : t_depth'(db + 1'b1);
        end
        if (i_op == OP_ATT_STEP) begin
            r_row[r_k] <= chain;
        end
    end

    // Clear sweep and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_op == OP_CLEAR) begin
                r_clr <= t_addr'(r_clr + 1'b1);
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_anc <= (i_op == OP_EMIT_UP) ? anc_of(i_rdata_a, '0) : r_a;
        end
    end

    assign o_flags.clr_busy  = (r_clr != t_addr'(NODES - 1));
    assign o_flags.no_txn    = !i_in_valid;
    assign o_flags.query     = r_query;
    assign o_flags.k_up_more = (r_k != t_lvl'(LEVELS - 1));
    assign o_flags.k_dn_more = (r_k != '0);
    assign o_flags.same      = (r_a == r_b);
    assign o_flags.out_busy  = out_busy;

    assign o_in_stall  = (i_op != OP_ACCEPT);
    assign o_out_valid = r_out_valid;
    assign o_ancestor  = r_out_anc;

    // Read ports follow the next node values so row data matches r_a, r_b
    assign o_raddr_a = t_addr'(n_a);
    assign o_raddr_b = t_addr'(n_b);

    always_comb begin
        if (i_op == OP_CLEAR) begin
            o_we    = 1'b1;
            o_waddr = r_clr;
            o_wdata = '0;
        end else begin
            o_we    = (i_op == OP_ATT_WRITE) && (r_a != '0);
            o_waddr = t_addr'(r_a);
            o_wdata = {r_dn, r_row};
        end
    end

endmodule

[hdl/tree_common_ancestor_lifting.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tree common ancestor by binary lifting
// Attach nodes to a rooted tree and answer lowest common ancestor queries.
// ----------------------------------------------------------------------------
// After reset the block sweeps zeros into all NODES rows of its row store
// and holds o_in_stall high until the sweep ends. Each node row holds the
// depth and the 2^k ancestors for every level, so one RAM read port per
// node gives a whole row. An attach transaction (req_type 0) follows the
// ancestor chain one level a cycle through a read port. A query
// transaction (req_type 1) makes one read per level to lift the deeper
// node and one per level to jump both nodes, using both read ports at
// once. When the lifted node already meets the other one the jump pass is
// skipped. Attaches must arrive parent first. A finished answer waits in
// the output register while the next transaction is accepted; a new
// answer waits only if the old one is still stalled, and the query then
// holds in its emit step until the stall clears.
// ----------------------------------------------------------------------------
module tree_common_ancestor_lifting (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic          i_req_type,
    input  tlca_pkg::t_id i_node_a,
    input  tlca_pkg::t_id i_node_b,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output tlca_pkg::t_id o_ancestor
);
    import tlca_pkg::*;

    t_op    op;
    t_flags flags;
    logic   we;
    t_addr  waddr, raddr_a, raddr_b;
    t_word  wdata, rdata_a, rdata_b;

    // Program sequencer: one control word per step
    tlca_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_op    (op)
    );

    // Datapath: node registers, level counter, row builder, result register
    tlca_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .o_flags     (flags),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req_type  (i_req_type),
        .i_node_a    (i_node_a),
        .i_node_b    (i_node_b),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_ancestor  (o_ancestor),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_raddr_a   (raddr_a),
        .o_raddr_b   (raddr_b),
        .i_rdata_a   (rdata_a),
        .i_rdata_b   (rdata_b)
    );

    // Row store: depth plus ancestor levels, one row per node id
    tlca_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NODES)
    ) u_rows (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .o_rdata_a (rdata_a),
        .i_raddr_b (raddr_b),
        .o_rdata_b (rdata_b)
    );

endmodule
